// ===== sv/xrs_pkg.sv =====
`timescale 1ns / 1ps

package xrs_pkg;

  typedef enum logic [2:0] {
    PH_STOPPED  = 3'd0,
    PH_DEFAULT  = 3'd1,
    PH_PREPARE  = 3'd2,
    PH_READY    = 3'd3,
    PH_SCAN     = 3'd4,
    PH_BACK     = 3'd5,
    PH_STEPNEXT = 3'd6,
    PH_END      = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    PAT_X_COMB  = 2'd0,
    PAT_X_SNAKE = 2'd1,
    PAT_Y_COMB  = 2'd2,
    PAT_Y_SNAKE = 2'd3
  } pattern_t;

  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_START_X      = 3'd0,
    REG_START_Y      = 3'd1,
    REG_END_X        = 3'd2,
    REG_END_Y        = 3'd3,
    REG_STEP_SIZE    = 3'd4,
    REG_SCAN_PATTERN = 3'd5
  } cfg_reg_t;

  localparam logic [1:0] IDLE_MASK = 2'b11;

  typedef struct packed {
    logic write_x;
    logic write_y;
    logic start_move;
    logic prepare_move;
  } move_flags_t;

endpackage

// ===== sv/xrs_cfg.sv =====
`timescale 1ns / 1ps

module xrs_cfg import xrs_pkg::*; #(
  parameter int POS_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [POS_BITS-1:0]       cfg_data,
  output logic [POS_BITS-1:0]       start_x,
  output logic [POS_BITS-1:0]       start_y,
  output logic [POS_BITS-1:0]       end_x,
  output logic [POS_BITS-1:0]       end_y,
  output logic [POS_BITS-1:0]       step_size,
  output pattern_t                  scan_pattern
);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x      <= '0;
      start_y      <= '0;
      end_x        <= '0;
      end_y        <= '0;
      step_size    <= '0;
      scan_pattern <= PAT_X_COMB;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_X:      start_x      <= cfg_data;
        REG_START_Y:      start_y      <= cfg_data;
        REG_END_X:        end_x        <= cfg_data;
        REG_END_Y:        end_y        <= cfg_data;
        REG_STEP_SIZE:    step_size    <= cfg_data;
        REG_SCAN_PATTERN: scan_pattern <= pattern_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/xrs_step.sv =====
`timescale 1ns / 1ps

module xrs_step import xrs_pkg::*; #(
  parameter int POS_BITS = 16
) (
  input  phase_t              phase,
  input  logic [POS_BITS-1:0] start_x,
  input  logic [POS_BITS-1:0] start_y,
  input  logic [POS_BITS-1:0] end_x,
  input  logic [POS_BITS-1:0] end_y,
  input  logic [POS_BITS-1:0] step_size,
  input  pattern_t            scan_pattern,
  input  logic                kind,
  input  logic [POS_BITS-1:0] cur_x,
  input  logic [POS_BITS-1:0] cur_y,
  input  logic [1:0]          axis_busy,
  output move_flags_t         flags,
  output logic [POS_BITS-1:0] target_x,
  output logic [POS_BITS-1:0] target_y,
  output phase_t              phase_next
);

  logic                fast_is_x;
  logic                snake;
  logic [POS_BITS-1:0] f, fs, fe, s, se;
  logic [POS_BITS:0]   adv_wide;
  logic [POS_BITS-1:0] adv;
  logic [POS_BITS-1:0] fs_clamped;
  logic                at_start;

  assign fast_is_x  = (scan_pattern == PAT_X_COMB) || (scan_pattern == PAT_X_SNAKE);
  assign snake      = (scan_pattern == PAT_X_SNAKE) || (scan_pattern == PAT_Y_SNAKE);
  assign f          = fast_is_x ? cur_x : cur_y;
  assign fs         = fast_is_x ? start_x : start_y;
  assign fe         = fast_is_x ? end_x : end_y;
  assign s          = fast_is_x ? cur_y : cur_x;
  assign se         = fast_is_x ? end_y : end_x;
  assign adv_wide   = {1'b0, s} + {1'b0, step_size};
  assign adv        = (adv_wide > {1'b0, se}) ? se : adv_wide[POS_BITS-1:0];
  assign fs_clamped = (fs > fe) ? fe : fs;
  assign at_start   = (cur_x == start_x) && (cur_y == start_y);

  always_comb begin
    phase_t              ph;
    logic                fw, sw;
    logic [POS_BITS-1:0] ft, st;
    ph       = phase;
    fw       = 1'b0;
    sw       = 1'b0;
    ft       = '0;
    st       = '0;
    flags    = '0;
    target_x = '0;
    target_y = '0;
    if (kind) begin
      ph = PH_DEFAULT;
    end else if (!(ph inside {PH_STOPPED, PH_END})) begin
      if (ph == PH_DEFAULT) begin
        if (!at_start) begin
          flags.write_x      = 1'b1;
          flags.write_y      = 1'b1;
          target_x           = (start_x > end_x) ? end_x : start_x;
          target_y           = (start_y > end_y) ? end_y : start_y;
          flags.prepare_move = 1'b1;
          ph                 = PH_PREPARE;
        end else begin
          ph = PH_READY;
        end
      end
      if (ph == PH_PREPARE && at_start) begin
        ph = PH_READY;
      end
      if ((ph inside {[PH_READY:PH_END]}) && ((axis_busy & IDLE_MASK) == 2'b00)) begin
        if (!snake) begin
          if (f == fs) begin
            if (ph == PH_BACK) begin
              sw               = 1'b1;
              st               = adv;
              flags.start_move = 1'b1;
              ph               = PH_STEPNEXT;
            end else if (ph inside {PH_STEPNEXT, PH_READY}) begin
              fw               = 1'b1;
              ft               = fe;
              flags.start_move = 1'b1;
            end
          end else if (f == fe) begin
            ph               = (s == se) ? PH_END : PH_BACK;
            fw               = 1'b1;
            ft               = fs_clamped;
            flags.start_move = 1'b1;
          end
        end else begin
          if (f == fs) begin
            if (ph inside {PH_STEPNEXT, PH_READY}) begin
              fw = 1'b1;
              ft = fe;
            end
            flags.start_move = 1'b1;
            ph               = PH_SCAN;
          end else if (f == fe) begin
            if (s == se) begin
              ph = PH_END;
            end else if (ph == PH_SCAN) begin
              sw               = 1'b1;
              st               = adv;
              flags.start_move = 1'b1;
              ph               = PH_STEPNEXT;
            end else begin
              fw               = 1'b1;
              ft               = fs_clamped;
              flags.start_move = 1'b1;
            end
          end
        end
        if (fw || sw) begin
          if (fast_is_x) begin
            flags.write_x = fw;
            target_x      = ft;
            flags.write_y = sw;
            target_y      = st;
          end else begin
            flags.write_y = fw;
            target_y      = ft;
            flags.write_x = sw;
            target_x      = st;
          end
        end
      end
    end
    phase_next = ph;
  end

endmodule

// ===== sv/xy_raster_scan_sequencer.sv =====
`timescale 1ns / 1ps
// XY raster scan sequencer.
// Input channel (in_valid/in_ready): one item per start event (kind = 1) or
// poll (kind = 0) carrying cur_x, cur_y and axis_busy of the stage.
// Output channel (out_valid/out_ready): exactly one item per input item with
// the X/Y targets and their write flags, start_move, prepare_move and the
// phase after the step. Targets not written read as zero.
// Configuration: cfg_we writes cfg_data into the register selected by
// cfg_index (start_x, start_y, end_x, end_y, step_size, scan_pattern);
// other indexes are ignored. Write only while no item is in flight.
// Pipeline: an accepted item is held in the input register, then moves into the
// result register, where it can be taken. Throughput is one item per cycle
// while out_ready stays high; the phase register is updated as each item moves
// from the input register to the result register, so consecutive items chain.
// Reset: phase returns to stopped, all configuration registers clear to 0,
// both pipeline stages empty.
// Stall: when out_ready is low the result holds, the input register fills,
// and in_ready drops until the result is taken.
module xy_raster_scan_sequencer import xrs_pkg::*; #(
  parameter int POS_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [POS_BITS-1:0]       cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      kind,
  input  logic [POS_BITS-1:0]       cur_x,
  input  logic [POS_BITS-1:0]       cur_y,
  input  logic [1:0]                axis_busy,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      write_target_x,
  output logic [POS_BITS-1:0]       target_x,
  output logic                      write_target_y,
  output logic [POS_BITS-1:0]       target_y,
  output logic                      start_move,
  output logic                      prepare_move,
  output logic [2:0]                phase_out
);

  logic [POS_BITS-1:0] start_x, start_y, end_x, end_y, step_size;
  pattern_t            scan_pattern;

  logic                s1_valid;
  logic                s1_kind;
  logic [POS_BITS-1:0] s1_cur_x, s1_cur_y;
  logic [1:0]          s1_busy;
  logic                s1_advance;

  phase_t              phase, phase_next;
  move_flags_t         flags;
  logic [POS_BITS-1:0] tx_next, ty_next;

  xrs_cfg #(.POS_BITS(POS_BITS)) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .step_size    (step_size),
    .scan_pattern (scan_pattern)
  );

  xrs_step #(.POS_BITS(POS_BITS)) u_step (
    .phase        (phase),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .step_size    (step_size),
    .scan_pattern (scan_pattern),
    .kind         (s1_kind),
    .cur_x        (s1_cur_x),
    .cur_y        (s1_cur_y),
    .axis_busy    (s1_busy),
    .flags        (flags),
    .target_x     (tx_next),
    .target_y     (ty_next),
    .phase_next   (phase_next)
  );

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind  <= kind;
      s1_cur_x <= cur_x;
      s1_cur_y <= cur_y;
      s1_busy  <= axis_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_STOPPED;
      out_valid <= 1'b0;
    end else begin
      if (s1_advance) begin
        phase <= phase_next;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      write_target_x <= flags.write_x;
      target_x       <= tx_next;
      write_target_y <= flags.write_y;
      target_y       <= ty_next;
      start_move     <= flags.start_move;
      prepare_move   <= flags.prepare_move;
      phase_out      <= phase_next;
    end
  end

endmodule
